// ===== hdl/bfa_pkg.sv =====
package bfa_pkg;

  // Default map size and page geometry
  localparam int unsigned FRAMES_DEF = 65536;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned LOW_FRAME  = 256;   // first frame at 1 MiB
  localparam int unsigned WORD_BITS  = 64;

  // Request codes
  localparam logic [2:0] REQ_ALLOC_ONE = 3'd0;
  localparam logic [2:0] REQ_FREE      = 3'd1;
  localparam logic [2:0] REQ_ALLOC_RUN = 3'd2;
  localparam logic [2:0] REQ_USABLE    = 3'd3;
  localparam logic [2:0] REQ_RESERVE   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;

  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

endpackage

// ===== hdl/bfa_map_ram.sv =====
module bfa_map_ram
  import bfa_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/bfa_zero_find.sv =====
module bfa_zero_find
  import bfa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  output logic                 full_o,
  output logic [5:0]           bit_o
);

  // Find the lowest clear bit, scanning from the top so the lowest wins
  always_comb begin
    full_o = &word_i;
    bit_o  = 6'd63;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        bit_o = 6'(i);
      end
    end
  end

endmodule

// ===== hdl/bitmap_frame_allocator.sv =====
// A single-frame request reads and checks map words one at a time from the hint, wrapping
// once to the start; range requests and runs walk frames one at a time through a
// one-word cache, fetching and writing back map words as needed; others finish at once.
// Throughput: one request at a time with busy_o high; done_o marks each result.
// After reset a clearing pass marks every frame used while busy_o is high; the
// page counters reset to zero, the hint to 256.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [47:0] start_addr_i,
  input  logic [47:0] end_addr_i,
  input  logic [16:0] page_count_i,
  input  logic [47:0] limit_addr_i,
  output logic        done_o,
  output logic [47:0] frame_addr_o,
  output logic [1:0]  status_o,
  output logic [16:0] free_pages_o,
  output logic [16:0] total_pages_o
);

  localparam int unsigned PW        = $clog2(FRAMES) + 1;
  localparam int unsigned MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned HW        = (PW > 9) ? PW : 9;
  localparam int unsigned LW        = (PW > 17) ? PW : 17;
  localparam int unsigned CW        = HW + 1;
  localparam int unsigned XW        = WW + 7;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ASCAN, S_AWAIT, S_ACHK, S_FRAME, S_FWAIT, S_FLOAD
  } state_e;

  typedef enum logic [2:0] {
    M_FREE, M_USE, M_RSV, M_RUN, M_MARK
  } mode_e;

  state_e           state_q;
  mode_e            mode_q;
  logic [16:0]      limit_q;
  logic [16:0]      free_q, usable_q, pages_q, run_q;
  logic [HW-1:0]    hint_q;
  logic [PW-1:0]    p_q, e_q, first_q;
  logic [WW:0]      w_q, stop_q, stop1_q;
  logic             pass_q;
  logic [WORD_BITS-1:0] cache_q;
  logic [WW-1:0]    cache_w_q;
  logic             cache_v_q, dirty_q;
  logic             we_q;
  logic [WW-1:0]    waddr_q, raddr_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic             done_q;
  logic [47:0]      addr_q;
  logic [1:0]       st_q;

  logic [WORD_BITS-1:0] rdata;
  logic             zf_full;
  logic [5:0]       zf_bit;

  // Shared map memory and lowest-free-bit unit
  bfa_map_ram #(.DEPTH(MAP_WORDS), .AW(WW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_q),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .raddr_i (raddr_q),
    .rdata_o (rdata)
  );

  bfa_zero_find u_zf (
    .word_i (rdata),
    .full_o (zf_full),
    .bit_o  (zf_bit)
  );

  // Effective frame limit
  logic [PW-1:0] eff;
  always_comb begin
    eff = (LW'(limit_q) > LW'(FRAMES)) ? PW'(FRAMES) : PW'(limit_q);
  end

  // Range set-up for a new request
  logic [36:0] p0, ecand, e_lim;
  logic        range_empty;
  logic [48:0] start_up, end_up;
  always_comb begin
    start_up = {1'b0, start_addr_i} + 49'(PAGE_BYTES - 1);
    end_up   = {1'b0, end_addr_i} + 49'(PAGE_BYTES - 1);
    case (req_type_i)
      REQ_FREE: begin
        p0    = 37'(start_addr_i[47:PAGE_SHIFT]);
        ecand = 37'(start_addr_i[47:PAGE_SHIFT]) + 37'(page_count_i);
      end
      REQ_USABLE: begin
        p0    = start_up[48:PAGE_SHIFT];
        ecand = 37'(end_addr_i[47:PAGE_SHIFT]);
      end
      REQ_RESERVE: begin
        p0    = 37'(start_addr_i[47:PAGE_SHIFT]);
        ecand = end_up[48:PAGE_SHIFT];
      end
      default: begin
        p0    = 37'(LOW_FRAME);
        ecand = 37'(limit_addr_i[47:PAGE_SHIFT]);
      end
    endcase
    e_lim       = (ecand > 37'(eff)) ? 37'(eff) : ecand;
    range_empty = (p0 >= e_lim);
  end

  // Word-scan set-up for single allocation
  logic [PW:0]   eff_up;
  logic [WW:0]   words;
  logic [HW-1:0] hw;
  logic [WW:0]   w0, stop1;
  always_comb begin
    eff_up = {1'b0, eff} + (PW+1)'(WORD_BITS - 1);
    words  = (WW+1)'(eff_up >> 6);
    hw     = hint_q >> 6;
    w0     = (CW'(hw) < CW'(words)) ? (WW+1)'(hw) : words;
    stop1  = (CW'(hw) + CW'(1) < CW'(words)) ? (WW+1)'(CW'(hw) + CW'(1)) : words;
  end

  // Frame loop helpers
  logic [WW-1:0]     p_word;
  logic              cur;
  logic [WW+5:0]     pfn;
  logic [PW-1:0]     run_first;
  always_comb begin
    p_word    = WW'(p_q >> 6);
    cur       = cache_q[p_q[5:0]];
    pfn       = {w_q[WW-1:0], zf_bit};
    run_first = (run_q == 17'd0) ? p_q : first_q;
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      mode_q    <= M_FREE;
      limit_q   <= 17'h10000;
      free_q    <= '0;
      usable_q  <= '0;
      pages_q   <= '0;
      run_q     <= '0;
      hint_q    <= HW'(LOW_FRAME);
      p_q       <= '0;
      e_q       <= '0;
      first_q   <= '0;
      w_q       <= '0;
      stop_q    <= '0;
      stop1_q   <= '0;
      pass_q    <= 1'b0;
      cache_q   <= '0;
      cache_w_q <= '0;
      cache_v_q <= 1'b0;
      dirty_q   <= 1'b0;
      we_q      <= 1'b0;
      waddr_q   <= '0;
      raddr_q   <= '0;
      wdata_q   <= '0;
      done_q    <= 1'b0;
      addr_q    <= '0;
      st_q      <= ST_OK;
    end else begin
      we_q   <= 1'b0;
      done_q <= 1'b0;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      unique case (state_q)
        // Mark every map word used
        S_CLEAR: begin
          we_q    <= 1'b1;
          waddr_q <= w_q[WW-1:0];
          wdata_q <= '1;
          if (w_q == (WW+1)'(MAP_WORDS - 1)) begin
            state_q <= S_IDLE;
          end else begin
            w_q <= w_q + 1'b1;
          end
        end

        // Take a request and set up the scan
        S_IDLE: begin
          if (start_i) begin
            addr_q    <= '0;
            st_q      <= ST_OK;
            pages_q   <= page_count_i;
            run_q     <= '0;
            cache_v_q <= 1'b0;
            dirty_q   <= 1'b0;
            p_q       <= PW'(p0);
            e_q       <= PW'(e_lim);
            case (req_type_i)
              REQ_ALLOC_ONE: begin
                w_q     <= w0;
                stop_q  <= words;
                stop1_q <= stop1;
                pass_q  <= 1'b0;
                state_q <= S_ASCAN;
              end
              REQ_FREE, REQ_USABLE, REQ_RESERVE: begin
                mode_q <= (req_type_i == REQ_FREE)   ? M_FREE :
                          (req_type_i == REQ_USABLE) ? M_USE : M_RSV;
                if (range_empty) begin
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_FRAME;
                end
              end
              REQ_ALLOC_RUN: begin
                mode_q <= M_RUN;
                if (range_empty || page_count_i == 17'd0) begin
                  st_q   <= ST_NOMEM;
                  done_q <= 1'b1;
                end else begin
                  state_q <= S_FRAME;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end

        // Issue the next word read, or advance the pass
        S_ASCAN: begin
          if (w_q < stop_q) begin
            raddr_q <= w_q[WW-1:0];
            state_q <= S_AWAIT;
          end else if (!pass_q) begin
            pass_q <= 1'b1;
            w_q    <= '0;
            stop_q <= stop1_q;
          end else begin
            st_q    <= ST_NOMEM;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end

        S_AWAIT: begin
          state_q <= S_ACHK;
        end

        // Check the word; take its lowest free bit if below the limit
        S_ACHK: begin
          if (zf_full) begin
            w_q     <= w_q + 1'b1;
            state_q <= S_ASCAN;
          end else if (XW'(pfn) >= XW'(eff)) begin
            w_q     <= stop_q;
            state_q <= S_ASCAN;
          end else begin
            we_q    <= 1'b1;
            waddr_q <= w_q[WW-1:0];
            wdata_q <= rdata | (64'd1 << zf_bit);
            free_q  <= free_q - 1'b1;
            hint_q  <= HW'(pfn);
            addr_q  <= 48'(pfn) << PAGE_SHIFT;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end

        // Walk frames one at a time through the word cache
        S_FRAME: begin
          if (p_q >= e_q) begin
            if (dirty_q) begin
              we_q    <= 1'b1;
              waddr_q <= cache_w_q;
              wdata_q <= cache_q;
            end
            if (mode_q == M_RUN) begin
              st_q   <= ST_NOMEM;
              addr_q <= '0;
            end
            cache_v_q <= 1'b0;
            dirty_q   <= 1'b0;
            done_q    <= 1'b1;
            state_q   <= S_IDLE;
          end else if (!cache_v_q || p_word != cache_w_q) begin
            if (dirty_q) begin
              we_q    <= 1'b1;
              waddr_q <= cache_w_q;
              wdata_q <= cache_q;
            end
            dirty_q   <= 1'b0;
            raddr_q   <= p_word;
            cache_w_q <= p_word;
            state_q   <= S_FWAIT;
          end else begin
            unique case (mode_q)
              M_FREE: begin
                if (!cur) begin
                  st_q <= ST_DOUBLE;
                end else begin
                  cache_q[p_q[5:0]] <= 1'b0;
                  dirty_q           <= 1'b1;
                  free_q            <= free_q + 1'b1;
                  if (HW'(p_q) < hint_q) begin
                    hint_q <= HW'(p_q);
                  end
                end
                p_q <= p_q + 1'b1;
              end
              M_USE: begin
                if (cur) begin
                  cache_q[p_q[5:0]] <= 1'b0;
                  dirty_q           <= 1'b1;
                  free_q            <= free_q + 1'b1;
                  if (usable_q != CNT_MAX) begin
                    usable_q <= usable_q + 1'b1;
                  end
                end
                p_q <= p_q + 1'b1;
              end
              M_RSV: begin
                if (!cur) begin
                  cache_q[p_q[5:0]] <= 1'b1;
                  dirty_q           <= 1'b1;
                  free_q            <= free_q - 1'b1;
                end
                p_q <= p_q + 1'b1;
              end
              M_RUN: begin
                if (cur) begin
                  run_q <= '0;
                  p_q   <= p_q + 1'b1;
                end else if (run_q + 1'b1 == pages_q) begin
                  mode_q <= M_MARK;
                  p_q    <= run_first;
                  e_q    <= run_first + PW'(pages_q);
                  addr_q <= 48'(run_first) << PAGE_SHIFT;
                  free_q <= free_q - pages_q;
                end else begin
                  run_q   <= run_q + 1'b1;
                  first_q <= run_first;
                  p_q     <= p_q + 1'b1;
                end
              end
              M_MARK: begin
                cache_q[p_q[5:0]] <= 1'b1;
                dirty_q           <= 1'b1;
                p_q               <= p_q + 1'b1;
              end
              default: begin
                p_q <= p_q + 1'b1;
              end
            endcase
          end
        end

        S_FWAIT: begin
          state_q <= S_FLOAD;
        end

        // Load the fetched word into the cache
        S_FLOAD: begin
          cache_q   <= rdata;
          cache_v_q <= 1'b1;
          state_q   <= S_FRAME;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign frame_addr_o  = addr_q;
  assign status_o      = st_q;
  assign free_pages_o  = free_q;
  assign total_pages_o = usable_q;

endmodule

// ===== hdl/bfa_checker.sv =====
module bfa_checker
  import bfa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [47:0] frame_addr_o,
  input logic [1:0]  status_o
);

  // An accepted request either finishes at once or keeps the unit busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("request accepted without progress");

  // A result is never shown while the unit is still busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result while busy");

  // Failed allocations report address zero
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_NOMEM |-> frame_addr_o == 48'd0)
    else $error("failed request with non-zero address");

  // Addresses are page aligned and status codes valid
  a_result_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> frame_addr_o[11:0] == 12'd0 && status_o != 2'd3)
    else $error("malformed result");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .done_o       (done_o),
  .frame_addr_o (frame_addr_o),
  .status_o     (status_o)
);
